// ===== rtl/core/bfsa_pkg.sv =====
package bfsa_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int LW = $clog2(HEAP_BYTES + 1);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_OFF = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [LW-1:0] length;
        logic          alloc;
    } seg_t;

    localparam int SW = AW + LW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FREE_NB,
        S_MERGE,
        S_DONE
    } fsm_t;

endpackage

// ===== rtl/core/best_fit_segment_allocator_top.sv =====
// Channel  Dir  Handshake              Payload
// s_axis   in   s_tvalid / s_tready    tdata: operation, request_size, block_offset
// m_axis   out  m_tvalid / m_tready    tdata: status, granted_offset
//
// One request at a time. An allocate scans every entry, then decides; a split
// then moves the entries above the best fit up one place and writes the remainder.
// A free scans to the hit, then decides, reads both neighbors, writes the merged
// entry and finishes; closing the gap moves the later entries down. A size-zero
// allocate answers without a scan, an unknown offset after a full scan. The
// segment RAM (one read and one write port) sets the pace.
// After reset a clearing pass rewrites entry zero and the rest of the
// MAX_SEGMENTS entries; no request is taken until it finishes.
// The result waits in an output register; the next request may run meanwhile
// and holds in its final state until that register empties.
module best_fit_segment_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [0] operation, [13:1] request_size, [25:14] block_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [13:2] granted_offset
);
    import bfsa_pkg::*;

    fsm_t state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [CW-1:0] count_reg, count_next;
    logic          op_reg, op_next;
    logic [LW-1:0] size_reg, size_next;
    logic [AW-1:0] off_reg, off_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan read pointer
    logic [CW-1:0] chk_reg, chk_next;     // index of data arriving
    logic          found_reg, found_next;
    logic [IW-1:0] best_reg, best_next;
    seg_t          best_seg_reg, best_seg_next;
    logic [CW-1:0] sh_reg, sh_next;       // shift pointer
    logic [1:0]    nb_reg, nb_next;       // neighbor read phase
    seg_t          prev_reg, prev_next, next_seg_reg, next_seg_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] gr_reg, gr_next;
    logic          mv_reg, mv_next;
    logic [1:0]    out_st_reg, out_st_next; // result held for the master side
    logic [AW-1:0] out_gr_reg, out_gr_next;
    logic [1:0]    merge_reg, merge_next; // [0] merge with next, [1] with prev
    logic [1:0]    rem_reg, rem_next;     // entries removed by the merge (gap width)

    logic we;
    logic [IW-1:0] waddr, raddr;
    seg_t wdata, rdata;
    logic [SW-1:0] rraw;

    bfsa_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(SW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rraw)
    );
    assign rdata = seg_t'(rraw);

    assign s_tready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, out_gr_reg, out_st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            clr_reg <= '0;
            clr_busy_reg <= 1'b1;
            count_reg <= CW'(1);
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            clr_busy_reg <= clr_busy_next;
            count_reg <= count_next;
            mv_reg <= mv_next;
        end
        op_reg <= op_next; size_reg <= size_next; off_reg <= off_next;
        idx_reg <= idx_next; chk_reg <= chk_next; found_reg <= found_next;
        best_reg <= best_next; best_seg_reg <= best_seg_next; sh_reg <= sh_next;
        nb_reg <= nb_next; prev_reg <= prev_next; next_seg_reg <= next_seg_next;
        st_reg <= st_next; gr_reg <= gr_next; merge_reg <= merge_next;
        rem_reg <= rem_next;
        out_st_reg <= out_st_next; out_gr_reg <= out_gr_next;
    end

    logic [LW-1:0] rest_w;

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; clr_busy_next = clr_busy_reg;
        count_next = count_reg; mv_next = mv_reg;
        op_next = op_reg; size_next = size_reg; off_next = off_reg;
        idx_next = idx_reg; chk_next = chk_reg; found_next = found_reg;
        best_next = best_reg; best_seg_next = best_seg_reg; sh_next = sh_reg;
        nb_next = nb_reg; prev_next = prev_reg; next_seg_next = next_seg_reg;
        st_next = st_reg; gr_next = gr_reg; merge_next = merge_reg;
        rem_next = rem_reg;
        out_st_next = out_st_reg; out_gr_next = out_gr_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = idx_reg[IW-1:0];
        rest_w = best_seg_reg.length - size_reg;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (clr_busy_reg) begin
                    // clear pass: entry zero is the whole heap
                    we = 1'b1;
                    waddr = clr_reg;
                    wdata.start = '0;
                    wdata.length = (clr_reg == '0) ? LW'(HEAP_BYTES) : '0;
                    wdata.alloc = 1'b0;
                    clr_next = clr_reg + IW'(1);
                    if (clr_reg == IW'(MAX_SEGMENTS - 1)) begin
                        clr_busy_next = 1'b0;
                    end
                end else if (s_tvalid && s_tready) begin
                    op_next = s_tdata[0];
                    size_next = s_tdata[13:1];
                    off_next = s_tdata[25:14];
                    idx_next = '0; chk_next = '0; found_next = 1'b0;
                    gr_next = '0;
                    rem_next = '0;
                    if (s_tdata[0] == OP_ALLOC && s_tdata[13:1] == '0) begin
                        st_next = ST_NO_FIT;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue read of idx, data for chk arrives next cycle
                raddr = idx_reg[IW-1:0];
                chk_next = idx_reg;
                idx_next = idx_reg + CW'(1);
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                raddr = idx_reg[IW-1:0];
                if (op_reg == OP_ALLOC) begin
                    if (!rdata.alloc && rdata.length >= size_reg &&
                        (!found_reg || rdata.length < best_seg_reg.length)) begin
                        found_next = 1'b1;
                        best_next = chk_reg[IW-1:0];
                        best_seg_next = rdata;
                    end
                end else if (rdata.start == off_reg) begin
                    found_next = 1'b1;
                    best_next = chk_reg[IW-1:0];
                    best_seg_next = rdata;
                end
                if ((op_reg == OP_FREE && rdata.start == off_reg) ||
                    chk_reg + CW'(1) >= count_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    chk_next = idx_reg;
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DECIDE: begin
                if (op_reg == OP_ALLOC) begin
                    if (!found_reg) begin
                        st_next = ST_NO_FIT;
                        state_next = S_DONE;
                    end else if (rest_w != '0 && count_reg >= CW'(MAX_SEGMENTS)) begin
                        st_next = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        we = 1'b1;
                        waddr = best_reg;
                        wdata.start = best_seg_reg.start;
                        wdata.length = size_reg;
                        wdata.alloc = 1'b1;
                        st_next = ST_OK;
                        gr_next = best_seg_reg.start;
                        if (rest_w != '0) begin
                            sh_next = count_reg;
                            state_next = S_SHIFT_RD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end else begin
                    if (!found_reg) begin
                        st_next = ST_BAD_OFF;
                        state_next = S_DONE;
                    end else begin
                        st_next = ST_OK;
                        nb_next = 2'd0;
                        raddr = best_reg + IW'(1);
                        state_next = S_FREE_NB;
                    end
                end
            end
            S_SHIFT_RD: begin
                // insert at best+1: move entries up from the top
                if (sh_reg == CW'(best_reg) + CW'(1)) begin
                    we = 1'b1;
                    waddr = sh_reg[IW-1:0];
                    wdata.start = best_seg_reg.start + AW'(size_reg);
                    wdata.length = rest_w;
                    wdata.alloc = 1'b0;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end else begin
                    raddr = IW'(sh_reg - CW'(1));
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                we = 1'b1;
                wdata = rdata;
                if (rem_reg != 2'd0) begin
                    // close the gap: entry sh moves rem places lower
                    waddr = IW'(sh_reg - CW'(rem_reg));
                    sh_next = sh_reg + CW'(1);
                    state_next = S_MERGE;
                end else begin
                    // open a slot: entry sh-1 moves up to sh
                    waddr = sh_reg[IW-1:0];
                    sh_next = sh_reg - CW'(1);
                    state_next = S_SHIFT_RD;
                end
            end
            S_FREE_NB: begin
                // phase 0: next arrives, request prev; phase 1: prev arrives
                raddr = best_reg - IW'(1);
                if (nb_reg == 2'd0) begin
                    next_seg_next = rdata;
                    nb_next = 2'd1;
                end else begin
                    prev_next = rdata;
                    merge_next[0] = (CW'(best_reg) + CW'(1) < count_reg) &&
                                    !next_seg_reg.alloc;
                    merge_next[1] = (best_reg != '0) && !rdata.alloc;
                    state_next = S_MERGE;
                    nb_next = 2'd2;
                end
            end
            S_MERGE: begin
                if (nb_reg == 2'd2) begin
                    // write the merged entry, then close the gap
                    we = 1'b1;
                    wdata.alloc = 1'b0;
                    wdata.length = best_seg_reg.length +
                                   (merge_reg[0] ? next_seg_reg.length : '0);
                    if (merge_reg[1]) begin
                        waddr = best_reg - IW'(1);
                        wdata.start = prev_reg.start;
                        wdata.length = wdata.length + prev_reg.length;
                    end else begin
                        waddr = best_reg;
                        wdata.start = best_seg_reg.start;
                    end
                    rem_next = 2'(merge_reg[0]) + 2'(merge_reg[1]);
                    // first entry after the removed ones
                    sh_next = CW'(best_reg) + CW'(merge_reg[0]) + CW'(1);
                    nb_next = 2'd3;
                    if (rem_next == 2'd0) begin
                        state_next = S_DONE;
                    end
                end else begin
                    // read source sh, write it rem places lower next cycle
                    if (sh_reg > count_reg || sh_reg == count_reg) begin
                        count_next = count_reg - CW'(rem_reg);
                        state_next = S_DONE;
                    end else begin
                        raddr = sh_reg[IW-1:0];
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_DONE: begin
                // hold until the output register is free or drains this cycle
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    out_st_next = st_reg;
                    out_gr_next = gr_reg;
                    rem_next = 2'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second request while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     count_reg != '0 && count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");
`endif
endmodule

// ===== rtl/core/bfsa_ram.sv =====
module bfsa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 26
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
